>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by the project's checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// The condition must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> hw/rtl/gbsp_pkg.sv
// ---------------------------------------------------------------------------
// Grid BFS shortest path package
// Widths, query and status types shared by the core, its cells and checker.
// ---------------------------------------------------------------------------
`default_nettype none

package gbsp_pkg;

    localparam int MAX_SIDE    = 32;
    localparam int COORD_W     = 6;
    localparam int DIST_W      = 10;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 16;

    // One decoded query, coordinates 0-based and side already clamped.
    typedef struct packed {
        logic [COORD_W-1:0] side;
        logic [COORD_W-1:0] start_row;
        logic [COORD_W-1:0] start_col;
        logic [COORD_W-1:0] end_row;
        logic [COORD_W-1:0] end_col;
        logic [COORD_W-1:0] block_row;
        logic [COORD_W-1:0] block_col;
        logic               has_block;
    } query_t;

    typedef struct packed {
        logic load;
        logic step;
    } cell_ctrl_t;

    typedef struct packed {
        logic hit;
        logic grew;
    } cell_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/grid_bfs_shortest_path_core.sv
// ---------------------------------------------------------------------------
// Grid BFS shortest path core
// Shortest 4-neighbour path on a square grid with one blocked cell.
// ---------------------------------------------------------------------------
// Usage: one query is taken on the slave stream (s_tvalid/s_tready) and one
// result is returned on the master stream (m_tvalid/m_tready). s_tready is
// high only while no query is in progress.
// The search runs as a wavefront through a chain of row cells, one cell per
// grid row; in every cycle of a running search each cell widens its visited
// bits by one step using the rows handed over by its two neighbours. A query
// whose end is reachable gives its result once the wavefront reaches the end;
// an unreachable end is reported once the wavefront stops growing. A query
// with start or end outside the grid is answered without a search step.
// The next query is taken in the cycle after the result is registered.
// When the receiver stalls, the result is held in the output register and a
// finished search waits for it to drain before it is written.
// Reset clears the controller and the output valid; no clearing pass is
// needed, as each query reloads every cell.
// ---------------------------------------------------------------------------
`default_nettype none

module grid_bfs_shortest_path_core #(
    parameter int MAX_SIDE = gbsp_pkg::MAX_SIDE
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // side, start_row, start_col, end_row, end_col, block_row, block_col
    // (6 bits each from bit 0), zero padded
    input  wire logic [gbsp_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // distance (10 bits from bit 0), zero padded
    output logic      [gbsp_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // reachable
    output logic      [0:0]                        m_tuser
);

    import gbsp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN
    } state_t;

    state_t              state_reg;
    query_t              query_reg, query_next;
    logic                ok_reg, ok_next;
    logic [DIST_W-1:0]   step_reg;
    logic                m_tvalid_reg;
    logic [DIST_W-1:0]   dist_reg;
    logic                reach_reg;

    logic [COORD_W-1:0]  in_side, side_eff;
    logic [COORD_W-1:0]  in_sr, in_sc, in_er, in_ec, in_br, in_bc;

    logic [MAX_SIDE-1:0] row_vis [MAX_SIDE];
    cell_status_t        cell_status [MAX_SIDE];
    logic [MAX_SIDE-1:0] hit_vec, grew_vec;
    logic                hit_any, grew_any, finish, out_free;
    cell_ctrl_t          ctrl;

    function automatic logic in_grid(input logic [COORD_W-1:0] v,
                                     input logic [COORD_W-1:0] side);
        in_grid = (v != '0) && (v <= side);
    endfunction

    // Input decode: clamp the side and turn coordinates into 0-based form.
    always_comb
    begin
        in_side = s_tdata[0*COORD_W +: COORD_W];
        in_sr   = s_tdata[1*COORD_W +: COORD_W];
        in_sc   = s_tdata[2*COORD_W +: COORD_W];
        in_er   = s_tdata[3*COORD_W +: COORD_W];
        in_ec   = s_tdata[4*COORD_W +: COORD_W];
        in_br   = s_tdata[5*COORD_W +: COORD_W];
        in_bc   = s_tdata[6*COORD_W +: COORD_W];
        if ({1'b0, in_side} > (COORD_W + 1)'(MAX_SIDE))
        begin
            side_eff = COORD_W'(MAX_SIDE);
        end
        else
        begin
            side_eff = in_side;
        end
        query_next.side      = side_eff;
        query_next.start_row = in_sr - COORD_W'(1);
        query_next.start_col = in_sc - COORD_W'(1);
        query_next.end_row   = in_er - COORD_W'(1);
        query_next.end_col   = in_ec - COORD_W'(1);
        query_next.block_row = in_br - COORD_W'(1);
        query_next.block_col = in_bc - COORD_W'(1);
        query_next.has_block = in_grid(in_br, side_eff) && in_grid(in_bc, side_eff);
        ok_next = in_grid(in_sr, side_eff) && in_grid(in_sc, side_eff)
                  && in_grid(in_er, side_eff) && in_grid(in_ec, side_eff);
    end

    generate
        for (genvar i = 0; i < MAX_SIDE; i++)
        begin : g_row
            logic [MAX_SIDE-1:0] up_vis, down_vis;

            if (i == 0)
            begin : g_top
                assign up_vis = '0;
            end
            else
            begin : g_mid_up
                assign up_vis = row_vis[i-1];
            end

            if (i == MAX_SIDE - 1)
            begin : g_bottom
                assign down_vis = '0;
            end
            else
            begin : g_mid_down
                assign down_vis = row_vis[i+1];
            end

            gbsp_row_cell #(
                .MAX_SIDE (MAX_SIDE),
                .ROW      (i)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .query    (query_reg),
                .up_vis   (up_vis),
                .down_vis (down_vis),
                .vis      (row_vis[i]),
                .status   (cell_status[i])
            );

            assign hit_vec[i]  = cell_status[i].hit;
            assign grew_vec[i] = cell_status[i].grew;
        end
    endgenerate

    assign hit_any  = |hit_vec;
    assign grew_any = |grew_vec;
    assign out_free = !m_tvalid_reg || m_tready;
    // The search ends when start or end is off the grid, the end cell is visited or the wavefront has stalled.
    assign finish   = !ok_reg || hit_any || !grew_any;

    assign ctrl.load = (state_reg == ST_LOAD);
    assign ctrl.step = (state_reg == ST_RUN) && !finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            dist_reg     <= '0;
            reach_reg    <= 1'b0;
        end
        else
        begin
            // A new result may replace one that leaves in the same cycle.
            if ((state_reg == ST_RUN) && finish && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    step_reg  <= '0;
                    state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    if (finish)
                    begin
                        if (out_free)
                        begin
                            reach_reg    <= ok_reg && hit_any;
                            dist_reg     <= (ok_reg && hit_any) ? step_reg : '0;
                            state_reg    <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg + DIST_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            query_reg <= query_next;
            ok_reg    <= ok_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - DIST_W){1'b0}}, dist_reg};
    assign m_tuser  = reach_reg;

endmodule

`default_nettype wire

>>> hw/rtl/gbsp_row_cell.sv
// ---------------------------------------------------------------------------
// Grid BFS row cell
// Holds the visited bits of one grid row and grows them by one step per
// cycle while its step control is high, from its own bits and those of the rows above and below.
// ---------------------------------------------------------------------------
`default_nettype none

module gbsp_row_cell #(
    parameter int MAX_SIDE = gbsp_pkg::MAX_SIDE,
    parameter int ROW      = 0
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire gbsp_pkg::cell_ctrl_t   ctrl,
    input  wire gbsp_pkg::query_t       query,
    input  wire logic [MAX_SIDE-1:0]    up_vis,
    input  wire logic [MAX_SIDE-1:0]    down_vis,
    output logic      [MAX_SIDE-1:0]    vis,
    output gbsp_pkg::cell_status_t      status
);

    import gbsp_pkg::*;

    localparam logic [COORD_W-1:0] ROW_ID = COORD_W'(ROW);

    logic [MAX_SIDE-1:0] vis_reg, vis_next;
    logic                grew_reg, grew_next;
    logic [MAX_SIDE-1:0] allow_reg, end_mask_reg;
    logic [MAX_SIDE-1:0] load_allow, load_start, load_end;
    logic [MAX_SIDE-1:0] grow_vis;
    logic                row_inside, row_blocked;

    always_comb
    begin
        row_inside  = ROW_ID < query.side;
        row_blocked = query.has_block && (ROW_ID == query.block_row);
        for (int c = 0; c < MAX_SIDE; c++)
        begin
            load_allow[c] = row_inside && (COORD_W'(c) < query.side)
                            && !(row_blocked && (COORD_W'(c) == query.block_col));
            load_start[c] = (ROW_ID == query.start_row) && (COORD_W'(c) == query.start_col);
            load_end[c]   = (ROW_ID == query.end_row) && (COORD_W'(c) == query.end_col);
        end
    end

    // A visited cell stays visited, even the start cell when it is the blocked one.
    assign grow_vis = vis_reg
                      | ((up_vis | down_vis | (vis_reg << 1) | (vis_reg >> 1)) & allow_reg);

    always_comb
    begin
        vis_next  = vis_reg;
        grew_next = grew_reg;
        if (ctrl.load)
        begin
            vis_next  = load_start;
            grew_next = 1'b1;
        end
        else if (ctrl.step)
        begin
            vis_next  = grow_vis;
            grew_next = |(grow_vis & ~vis_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vis_reg  <= '0;
            grew_reg <= 1'b0;
        end
        else
        begin
            vis_reg  <= vis_next;
            grew_reg <= grew_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            allow_reg    <= load_allow;
            end_mask_reg <= load_end;
        end
    end

    assign vis         = vis_reg;
    assign status.hit  = |(vis_reg & end_mask_reg);
    assign status.grew = grew_reg;

endmodule

`default_nettype wire

>>> hw/rtl/gbsp_checker.sv
// ---------------------------------------------------------------------------
// Grid BFS shortest path checker
// Port-level assertions on the core, attached by a bind statement.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gbsp_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [gbsp_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input wire logic [0:0]                        m_tuser
);

    import gbsp_pkg::*;

    // A stalled result keeps its valid and its contents.
    `ASSERT_CLK(a_out_hold, clk, rst_n,
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)),
        "stalled result changed")

    // Only one query is in progress at a time.
    `ASSERT_CLK(a_one_query, clk, rst_n,
        (s_tvalid && s_tready) |=> !s_tready,
        "query taken while another is in progress")

    // An unreachable end reports a zero distance.
    `ASSERT_NEVER(a_unreach_zero, clk, rst_n,
        m_tvalid && !m_tuser[0] && (m_tdata[DIST_W-1:0] != '0),
        "unreachable result with non-zero distance")

    // Padding above the distance field stays clear.
    `ASSERT_NEVER(a_pad_zero, clk, rst_n,
        m_tvalid && (m_tdata[OUT_TDATA_W-1:DIST_W] != '0),
        "result padding bits set")

endmodule

bind grid_bfs_shortest_path_core gbsp_checker u_gbsp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

>>> tb/sv/gbsp_path_checker.sv
// ---------------------------------------------------------------------------
// Grid BFS shortest path checker
// Watches both stream channels of the core. Every query transfer is run
// through a breadth-first search of its own to give the expected distance
// and reachable flag. Each result transfer is then compared with the oldest
// expected result.
// ---------------------------------------------------------------------------

module gbsp_path_checker
    import gbsp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    // side, start_row, start_col, end_row, end_col, block_row, block_col
    // (6 bits each from bit 0), zero padded
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    // distance (10 bits from bit 0), zero padded
    input  wire logic [OUT_TDATA_W-1:0] m_tdata,
    // reachable
    input  wire logic [0:0]             m_tuser,
    output int                          fail_count,
    output int                          pending_results
);

    localparam int GRID_CELLS = MAX_SIDE * MAX_SIDE;

    // Query fields as they arrive on the bus, 1-based and unclamped.
    typedef struct packed {
        logic [COORD_W-1:0] block_col;
        logic [COORD_W-1:0] block_row;
        logic [COORD_W-1:0] end_col;
        logic [COORD_W-1:0] end_row;
        logic [COORD_W-1:0] start_col;
        logic [COORD_W-1:0] start_row;
        logic [COORD_W-1:0] side;
    } path_query_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              reachable;
    } path_result_t;

    path_result_t expected_paths [$];

    initial
    begin
        fail_count      = 0;
        pending_results = 0;
    end

    task automatic report_failure(input string msg);
        $display("[%0t] path check: %s", $time, msg);
        fail_count++;
    endtask

    // Converts a 1-based coordinate to 0-based, or -1 when it lies off the grid.
    function automatic int grid_coord(input logic [COORD_W-1:0] raw, input int side);
        if (int'(raw) < 1 || int'(raw) > side)
            return -1;
        return int'(raw) - 1;
    endfunction

    function automatic path_result_t predict_shortest_path(input path_query_t q);
        bit                seen [GRID_CELLS];
        logic [DIST_W-1:0] steps [GRID_CELLS];
        int                fifo [GRID_CELLS];
        int                step_row [4];
        int                step_col [4];
        int                head, tail, side, cur_cell, nr, nc, ni, k;
        int                sr, sc, er, ec, br, bc;
        bit                has_block;
        path_result_t      res;

        // Neighbour order: up, left, right, down.
        step_row = '{-1, 0, 0, 1};
        step_col = '{0, -1, 1, 0};
        res = '0;
        side = (int'(q.side) > MAX_SIDE) ? MAX_SIDE : int'(q.side);
        sr = grid_coord(q.start_row, side);
        sc = grid_coord(q.start_col, side);
        er = grid_coord(q.end_row, side);
        ec = grid_coord(q.end_col, side);
        br = grid_coord(q.block_row, side);
        bc = grid_coord(q.block_col, side);
        has_block = (br >= 0) && (bc >= 0);
        if (sr < 0 || sc < 0 || er < 0 || ec < 0)
            return res;

        foreach (seen[i])
            seen[i] = 1'b0;
        // The start cell is entered even when it is the blocked one.
        fifo[0] = sr * MAX_SIDE + sc;
        seen[fifo[0]] = 1'b1;
        steps[fifo[0]] = '0;
        head = 0;
        tail = 1;
        while (head < tail)
        begin
            cur_cell = fifo[head];
            head++;
            for (k = 0; k < 4; k++)
            begin
                nr = cur_cell / MAX_SIDE + step_row[k];
                nc = cur_cell % MAX_SIDE + step_col[k];
                if (nr < 0 || nc < 0 || nr >= side || nc >= side)
                    continue;
                if (has_block && nr == br && nc == bc)
                    continue;
                ni = nr * MAX_SIDE + nc;
                if (seen[ni])
                    continue;
                seen[ni] = 1'b1;
                steps[ni] = steps[cur_cell] + 1'b1;
                fifo[tail] = ni;
                tail++;
            end
        end

        if (seen[er * MAX_SIDE + ec])
        begin
            res.distance  = steps[er * MAX_SIDE + ec];
            res.reachable = 1'b1;
        end
        return res;
    endfunction

    always @(posedge clk)
    begin : monitor
        path_result_t got;
        path_result_t want;

        if (rst_n)
        begin
            // A result never leaves in the cycle of its own query, so the
            // result side is handled first.
            if (m_tvalid && m_tready)
            begin
                got.distance  = m_tdata[DIST_W-1:0];
                got.reachable = m_tuser[0];
                if (expected_paths.size() == 0)
                    report_failure($sformatf(
                        "result transfer with none expected: distance %0d reachable %0d",
                        got.distance, got.reachable));
                else
                begin
                    want = expected_paths.pop_front();
                    if (got.distance !== want.distance)
                        report_failure($sformatf("distance is %0d, expected %0d",
                                                 got.distance, want.distance));
                    if (got.reachable !== want.reachable)
                        report_failure($sformatf("reachable is %0b, expected %0b",
                                                 got.reachable, want.reachable));
                end
            end
            if (s_tvalid && s_tready)
                expected_paths.push_back(
                    predict_shortest_path(path_query_t'(s_tdata[7*COORD_W-1:0])));
            pending_results = expected_paths.size();
        end
    end

endmodule

>>> tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// Grid BFS shortest path core testbench
// Sends a directed set of corner-case queries followed by random ones, with
// random gaps on the query side and random stalls on the result side. A long
// result stall fills the core, and one pause lets every result drain. The
// checker beside the core predicts and compares every result.
// ---------------------------------------------------------------------------

module tb_top;

    import gbsp_pkg::*;

    localparam int RANDOM_QUERIES   = 120;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 256;
    localparam int WATCHDOG_LIMIT   = 20000;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [0:0]             m_tuser;

    int                     fail_count;
    int                     pending_results;
    int                     idle_cycles;
    bit                     hold_request;
    bit                     quiet_phase;

    grid_bfs_shortest_path_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    gbsp_path_checker path_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
        clk = 1'b0;

    always #1 clk = ~clk;

    // Ends the run if no transfer happens on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** grid_bfs_shortest_path_core: FAILED **");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random stall bursts, and one long hold-off on request.
    initial
    begin : receiver
        int hold_count;

        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_tready = 1'b0;
                for (hold_count = 0; hold_count < LONG_HOLD_CYCLES; hold_count++)
                    @(negedge clk);
                hold_request = 1'b0;
                m_tready = 1'b1;
            end
            else if (!quiet_phase && $urandom_range(0, 9) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                m_tready = 1'b1;
            end
            else
                m_tready = 1'b1;
        end
    end

    // Offers one query and returns at the falling edge after its transfer.
    task automatic send_query(input logic [COORD_W-1:0] side,
                              input logic [COORD_W-1:0] start_row,
                              input logic [COORD_W-1:0] start_col,
                              input logic [COORD_W-1:0] end_row,
                              input logic [COORD_W-1:0] end_col,
                              input logic [COORD_W-1:0] block_row,
                              input logic [COORD_W-1:0] block_col);
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        s_tdata = '0;
        s_tdata[7*COORD_W-1:0] = {block_col, block_row, end_col, end_row,
                                  start_col, start_row, side};
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        int                 idx;
        int                 kind;
        int unsigned        lim;
        logic [COORD_W-1:0] side, sr, sc, er, ec, br, bc;

        s_tvalid     = 1'b0;
        s_tdata      = '0;
        rst_n        = 1'b0;
        idle_cycles  = 0;
        hold_request = 1'b0;
        quiet_phase  = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed corner cases.
        send_query(32, 1, 1, 32, 32, 16, 16);   // longest path on the full grid
        send_query(1, 1, 1, 1, 1, 2, 2);        // single cell, block off the grid
        send_query(0, 1, 1, 1, 1, 1, 1);        // empty grid
        send_query(63, 1, 1, 32, 32, 0, 0);     // side clamped, no block
        send_query(40, 1, 1, 33, 1, 2, 2);      // end beyond the clamped side
        send_query(8, 0, 1, 3, 3, 2, 2);        // start row zero
        send_query(8, 1, 63, 3, 3, 2, 2);       // start column far outside
        send_query(8, 1, 1, 0, 3, 2, 2);        // end row zero
        send_query(32, 1, 1, 5, 33, 2, 2);      // end column just outside
        send_query(8, 5, 5, 5, 5, 1, 1);        // start equals end
        send_query(8, 3, 3, 3, 6, 3, 3);        // start on the blocked cell
        send_query(8, 1, 1, 4, 4, 4, 4);        // end on the blocked cell
        send_query(8, 4, 4, 4, 4, 4, 4);        // start, end and block coincide
        send_query(5, 1, 1, 1, 3, 1, 2);        // block forces a detour
        send_query(2, 1, 1, 2, 2, 1, 2);
        send_query(2, 2, 2, 1, 1, 2, 1);
        send_query(1, 1, 1, 1, 1, 1, 1);
        send_query(4, 1, 4, 4, 1, 0, 2);        // block row outside the grid
        send_query(32, 1, 32, 32, 1, 1, 31);
        send_query(63, 63, 63, 63, 63, 63, 63); // every bit set
        send_query(32, 32, 32, 1, 1, 32, 31);

        for (idx = 0; idx < RANDOM_QUERIES; idx++)
        begin
            if (idx == 40)
                hold_request = 1'b1;
            if (idx == 80)
            begin
                s_tvalid = 1'b0;
                wait (pending_results == 0);
                @(negedge clk);
            end
            if (idx == 100)
                quiet_phase = 1'b1;

            kind = $urandom_range(0, 99);
            if (kind < 75)
            begin
                // Well-formed query: start and end always on the grid.
                if (kind < 5)
                    side = COORD_W'($urandom_range(33, 63));
                else if (kind < 20)
                    side = COORD_W'($urandom_range(1, 4));
                else
                    side = COORD_W'($urandom_range(1, 32));
                lim = (side > MAX_SIDE) ? MAX_SIDE : side;
                sr = COORD_W'($urandom_range(1, lim));
                sc = COORD_W'($urandom_range(1, lim));
                er = COORD_W'($urandom_range(1, lim));
                ec = COORD_W'($urandom_range(1, lim));
                if ($urandom_range(0, 9) == 0)
                begin
                    er = sr;
                    ec = sc;
                end
                case ($urandom_range(0, 9))
                    0:
                    begin
                        br = er;
                        bc = ec;
                    end
                    1:
                    begin
                        br = sr;
                        bc = sc;
                    end
                    2:
                    begin
                        br = COORD_W'($urandom_range(0, 63));
                        bc = COORD_W'($urandom_range(0, 63));
                    end
                    default:
                    begin
                        br = COORD_W'($urandom_range(1, lim));
                        bc = COORD_W'($urandom_range(1, lim));
                    end
                endcase
            end
            else
            begin
                side = COORD_W'($urandom_range(0, 63));
                sr   = COORD_W'($urandom_range(0, 63));
                sc   = COORD_W'($urandom_range(0, 63));
                er   = COORD_W'($urandom_range(0, 63));
                ec   = COORD_W'($urandom_range(0, 63));
                br   = COORD_W'($urandom_range(0, 63));
                bc   = COORD_W'($urandom_range(0, 63));
            end
            send_query(side, sr, sc, er, ec, br, bc);
        end

        s_tvalid = 1'b0;
        wait (pending_results == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("** grid_bfs_shortest_path_core: PASSED **");
        else
            $display("** grid_bfs_shortest_path_core: FAILED **");
        $finish;
    end

endmodule

>>> grid_bfs_shortest_path_core.f
+incdir+hw/rtl
hw/rtl/gbsp_pkg.sv
hw/rtl/gbsp_row_cell.sv
hw/rtl/grid_bfs_shortest_path_core.sv
hw/rtl/gbsp_checker.sv
tb/sv/gbsp_path_checker.sv
tb/sv/tb_top.sv
